/* rtl/core/srt_pkg.sv */
// Shared types and codes for the sensor reading table.
// Holds mode, status, update and config codes, limit defaults and the slot, probe and update structs.
// No dependencies.
package srt_pkg;

    localparam logic [2:0] MODE_READ  = 3'd0;
    localparam logic [2:0] MODE_TICK  = 3'd1;
    localparam logic [2:0] MODE_SET   = 3'd2;
    localparam logic [2:0] MODE_CLEAR = 3'd3;
    localparam logic [2:0] MODE_QUERY = 3'd4;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_ALARM     = 3'd1;
    localparam logic [2:0] STAT_FULL      = 3'd2;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [2:0] STAT_EMPTY     = 3'd4;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_TICK  = 3'd1;
    localparam logic [2:0] OP_READ  = 3'd2;
    localparam logic [2:0] OP_SET   = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    localparam logic [1:0] CFG_LOW_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_HIGH_LIMIT = 2'd1;
    localparam logic [1:0] CFG_MISSED_CAP = 2'd2;

    localparam logic signed [7:0] LOW_LIMIT_RST  = -8'sd20;
    localparam logic signed [8:0] HIGH_LIMIT_RST = 9'sd128;
    localparam logic [7:0]        MISSED_CAP_RST = 8'd250;

    localparam logic [6:0] HUND_MAX   = 7'd99;
    localparam logic [6:0] HUND_ROUND = 7'd50;
    localparam logic [4:0] FRAC_SCALE = 5'd25;

    typedef struct packed {
        logic       valid;
        logic       ovr;
        logic       neg;
        logic [7:0] whole;
        logic [6:0] hund;
        logic [7:0] missed;
    } slot_data_t;

    typedef struct packed {
        logic       hit;
        logic       free;
        slot_data_t data;
    } probe_t;

    typedef struct packed {
        logic [2:0]  op;
        logic        alloc;
        logic [63:0] key;
        logic        neg;
        logic [7:0]  whole;
        logic [6:0]  hund;
        logic        hund_wr;
        logic [7:0]  cap;
    } upd_t;

endpackage

/* rtl/core/srt_cell.sv */
// One slot of the sensor reading table chain: holds the slot state and
// refines the probe handed on from its neighbour. Depends on srt_pkg.
module srt_cell
    import srt_pkg::*;
#(
    parameter int IDX = 0,
    parameter int IW  = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          query,
    input  logic [63:0]   key,
    input  logic [3:0]    q,
    input  probe_t        probe_in,
    input  logic [IW-1:0] hit_idx_in,
    input  logic [IW-1:0] free_idx_in,
    output probe_t        probe_out,
    output logic [IW-1:0] hit_idx_out,
    output logic [IW-1:0] free_idx_out,
    input  upd_t          upd,
    input  logic [IW-1:0] upd_idx
);

    logic          used_reg, used_next;
    logic [63:0]   key_reg, key_next;
    slot_data_t    data_reg, data_next;
    probe_t        probe_reg, probe_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic          own_match, own_free, own_sel;

    assign own_match = query ? (32'(q) == IDX) : (used_reg && key_reg == key);
    assign own_free  = !query && !used_reg;
    assign own_sel   = (upd_idx == IW'(IDX));

    always_comb begin
        probe_next    = probe_in;
        hit_idx_next  = hit_idx_in;
        free_idx_next = free_idx_in;
        if (!probe_in.hit && own_match) begin
            probe_next.hit  = 1'b1;
            probe_next.data = data_reg;
            hit_idx_next    = IW'(IDX);
        end else if (!probe_in.hit && !probe_in.free && own_free) begin
            probe_next.free = 1'b1;
            probe_next.data = data_reg;
            free_idx_next   = IW'(IDX);
        end
    end

    always_comb begin
        used_next = used_reg;
        key_next  = key_reg;
        data_next = data_reg;
        if (upd.op == OP_TICK) begin
            if (used_reg && data_reg.missed < upd.cap) begin
                data_next.missed = data_reg.missed + 8'd1;
            end
        end else if (own_sel) begin
            if (upd.alloc) begin
                used_next = 1'b1;
                key_next  = upd.key;
            end
            case (upd.op)
                OP_READ: begin
                    data_next.valid = 1'b1;
                    if (!data_reg.ovr) begin
                        data_next.neg    = upd.neg;
                        data_next.whole  = upd.whole;
                        data_next.hund   = upd.hund;
                        data_next.missed = 8'd0;
                    end
                end
                OP_SET: begin
                    data_next.valid = 1'b1;
                    data_next.ovr   = 1'b1;
                    data_next.neg   = upd.neg;
                    data_next.whole = upd.whole;
                    if (upd.hund_wr) begin
                        data_next.hund = upd.hund;
                    end
                end
                OP_CLEAR: begin
                    data_next.valid = 1'b0;
                    data_next.ovr   = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= 1'b0;
            data_reg  <= '0;
            probe_reg <= '0;
        end else begin
            used_reg  <= used_next;
            data_reg  <= data_next;
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
    end

    assign probe_out    = probe_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign free_idx_out = free_idx_reg;

endmodule

/* rtl/core/sensor_reading_table.sv */
// Sensor reading table: a chain of SLOTS cells searched by a registered probe.
// The probe walks the cell chain one cell per cycle; a new item is taken only in the
// idle state, once the previous item has passed its finish state.
// A new item is taken while a finished result still waits on the output.
// Synchronous active-low reset clears all slots and loads the limit defaults.
// Depends on srt_pkg and srt_cell.
module sensor_reading_table
    import srt_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [8:0]                 cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [2:0]                 s_mode,
    input  logic [63:0]                s_sensor_id,
    input  logic [15:0]                s_raw_reading,
    input  logic signed [8:0]          s_override_whole,
    input  logic [6:0]                 s_override_fract,
    input  logic                       s_fract_given,
    input  logic [3:0]                 s_slot_index,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [2:0]                 m_status,
    output logic [$clog2(SLOTS+1)-1:0] m_slot,
    output logic                       m_negative,
    output logic [7:0]                 m_whole,
    output logic [6:0]                 m_fract,
    output logic [8:0]                 m_rounded_whole,
    output logic [7:0]                 m_missed,
    output logic                       m_overridden,
    output logic                       m_is_set,
    output logic signed [11:0]         m_alarm_value
);

    localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLW = $clog2(SLOTS + 1);
    localparam logic [SLW-1:0] SLOT_NONE = SLW'(SLOTS);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WALK   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]   state_reg, state_next;
    logic [IW-1:0] cnt_reg, cnt_next;

    logic signed [7:0] low_limit_reg;
    logic signed [8:0] high_limit_reg;
    logic [7:0]        missed_cap_reg;

    logic [2:0]        mode_reg;
    logic [63:0]       id_reg;
    logic [15:0]       raw_reg;
    logic signed [8:0] ow_reg;
    logic [6:0]        of_reg;
    logic              fg_reg;
    logic [3:0]        q_reg;

    probe_t        probe_q [SLOTS];
    logic [IW-1:0] hidx_q  [SLOTS];
    logic [IW-1:0] fidx_q  [SLOTS];

    upd_t          upd;
    logic [IW-1:0] upd_idx;

    logic              s_fire, fin_fire;
    probe_t            pr;
    logic [16:0]       mag;
    logic [11:0]       whole_c;
    logic [8:0]        frac_prod;
    logic signed [12:0] val;
    logic              val_neg, in_range;
    logic signed [9:0] ow_x;
    logic [9:0]        ow_mag;
    logic [7:0]        ow_sat;
    logic [6:0]        of_sat;

    logic [2:0]        r_status;
    logic [SLW-1:0]    r_slot;
    slot_data_t        r_data;
    logic              r_show;
    logic signed [11:0] r_alarm;
    upd_t              u_c;
    logic [IW-1:0]     u_idx_c;

    logic              m_valid_reg;
    logic [2:0]        status_reg;
    logic [SLW-1:0]    slot_reg;
    slot_data_t        data_out_reg;
    logic signed [11:0] alarm_reg;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign fin_fire  = (state_reg == S_FINISH) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    state_next = S_WALK;
                    cnt_next   = '0;
                end
            end
            S_WALK: begin
                if (cnt_reg == IW'(SLOTS - 1)) begin
                    state_next = S_FINISH;
                end else begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end
            S_FINISH: begin
                if (fin_fire) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            low_limit_reg  <= LOW_LIMIT_RST;
            high_limit_reg <= HIGH_LIMIT_RST;
            missed_cap_reg <= MISSED_CAP_RST;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_LOW_LIMIT:  low_limit_reg  <= cfg_data[7:0];
                    CFG_HIGH_LIMIT: high_limit_reg <= cfg_data;
                    CFG_MISSED_CAP: missed_cap_reg <= cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            mode_reg <= s_mode;
            id_reg   <= s_sensor_id;
            raw_reg  <= s_raw_reading;
            ow_reg   <= s_override_whole;
            of_reg   <= s_override_fract;
            fg_reg   <= s_fract_given;
            q_reg    <= s_slot_index;
        end
    end

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        probe_t        p_in;
        logic [IW-1:0] h_in, f_in;
        if (i == 0) begin : g_head
            assign p_in = '0;
            assign h_in = '0;
            assign f_in = '0;
        end else begin : g_link
            assign p_in = probe_q[i-1];
            assign h_in = hidx_q[i-1];
            assign f_in = fidx_q[i-1];
        end
        srt_cell #(
            .IDX(i),
            .IW (IW)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .query       (mode_reg == MODE_QUERY),
            .key         (id_reg),
            .q           (q_reg),
            .probe_in    (p_in),
            .hit_idx_in  (h_in),
            .free_idx_in (f_in),
            .probe_out   (probe_q[i]),
            .hit_idx_out (hidx_q[i]),
            .free_idx_out(fidx_q[i]),
            .upd         (upd),
            .upd_idx     (upd_idx)
        );
    end

    assign pr = probe_q[SLOTS-1];

    assign mag       = raw_reg[15] ? (17'h10000 - {1'b0, raw_reg}) : {1'b0, raw_reg};
    assign whole_c   = mag[15:4];
    assign frac_prod = 9'(mag[3:0]) * 9'(FRAC_SCALE);
    assign val       = raw_reg[15] ? -$signed({1'b0, whole_c}) : $signed({1'b0, whole_c});
    assign val_neg   = raw_reg[15] && (whole_c != 12'd0);
    assign in_range  = !(val < 13'(low_limit_reg)) && !(val > 13'(high_limit_reg));

    assign ow_x   = 10'(ow_reg);
    assign ow_mag = ow_reg[8] ? 10'(-ow_x) : 10'(ow_x);
    assign ow_sat = (ow_mag > 10'd255) ? 8'hff : ow_mag[7:0];
    assign of_sat = (of_reg > HUND_MAX) ? HUND_MAX : of_reg;

    always_comb begin
        r_status = STAT_OK;
        r_slot   = SLOT_NONE;
        r_data   = pr.data;
        r_show   = 1'b0;
        r_alarm  = '0;
        u_c      = '0;
        u_c.key  = id_reg;
        u_c.cap  = missed_cap_reg;
        u_idx_c  = pr.hit ? hidx_q[SLOTS-1] : fidx_q[SLOTS-1];
        unique case (mode_reg)
            MODE_READ: begin
                if (!pr.hit && !pr.free) begin
                    r_status = STAT_FULL;
                end else begin
                    u_c.alloc = !pr.hit;
                    r_slot    = SLW'(u_idx_c);
                    r_show    = 1'b1;
                    if (in_range) begin
                        u_c.op    = OP_READ;
                        u_c.neg   = val_neg;
                        u_c.whole = whole_c[7:0];
                        u_c.hund  = frac_prod[8:2];
                        r_data.valid = 1'b1;
                        if (!pr.data.ovr) begin
                            r_data.neg    = val_neg;
                            r_data.whole  = whole_c[7:0];
                            r_data.hund   = frac_prod[8:2];
                            r_data.missed = 8'd0;
                        end
                    end else begin
                        r_status = STAT_ALARM;
                        r_alarm  = val[11:0];
                    end
                end
            end
            MODE_TICK: begin
                u_c.op = OP_TICK;
            end
            MODE_SET, MODE_CLEAR: begin
                if (!pr.hit) begin
                    r_status = STAT_NOT_FOUND;
                end else begin
                    r_slot = SLW'(u_idx_c);
                    r_show = 1'b1;
                    if (mode_reg == MODE_SET) begin
                        u_c.op      = OP_SET;
                        u_c.neg     = ow_reg[8];
                        u_c.whole   = ow_sat;
                        u_c.hund    = of_sat;
                        u_c.hund_wr = fg_reg;
                        r_data.valid = 1'b1;
                        r_data.ovr   = 1'b1;
                        r_data.neg   = ow_reg[8];
                        r_data.whole = ow_sat;
                        if (fg_reg) begin
                            r_data.hund = of_sat;
                        end
                    end else begin
                        u_c.op       = OP_CLEAR;
                        r_data.valid = 1'b0;
                        r_data.ovr   = 1'b0;
                    end
                end
            end
            MODE_QUERY: begin
                if (32'(q_reg) >= SLOTS || !pr.hit) begin
                    r_status = STAT_EMPTY;
                end else begin
                    r_slot = SLW'(hidx_q[SLOTS-1]);
                    if (!pr.data.valid) begin
                        r_status = STAT_EMPTY;
                    end else begin
                        r_show = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        upd     = u_c;
        upd_idx = u_idx_c;
        if (!fin_fire) begin
            upd.op    = OP_NONE;
            upd.alloc = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_fire) begin
            status_reg   <= r_status;
            slot_reg     <= r_slot;
            data_out_reg <= r_show ? r_data : '0;
            alarm_reg    <= r_alarm;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_slot          = slot_reg;
    assign m_negative      = data_out_reg.neg;
    assign m_whole         = data_out_reg.whole;
    assign m_fract         = data_out_reg.hund;
    assign m_rounded_whole = 9'(data_out_reg.whole) + 9'(data_out_reg.hund > HUND_ROUND);
    assign m_missed        = data_out_reg.missed;
    assign m_overridden    = data_out_reg.ovr;
    assign m_is_set        = data_out_reg.valid;
    assign m_alarm_value   = alarm_reg;

endmodule

/* rtl/core/srt_checker.sv */
// Port-level checks for the sensor reading table, bound to the top level.
// Depends on srt_pkg and sensor_reading_table.
module srt_checker
    import srt_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [2:0]                 m_status,
    input logic [$clog2(SLOTS+1)-1:0] m_slot,
    input logic [7:0]                 m_whole,
    input logic [7:0]                 m_missed,
    input logic                       m_overridden,
    input logic                       m_is_set,
    input logic signed [11:0]         m_alarm_value
);

    localparam int SLW = $clog2(SLOTS + 1);

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot))
        else $error("result changed while stalled");

    // one item in flight: input closes after a transfer
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in flight");

    a_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_slot == SLW'(SLOTS) |-> !m_is_set && m_whole == 8'd0
            && m_missed == 8'd0 && !m_overridden && m_status != STAT_ALARM)
        else $error("slot fields shown with no slot");

    a_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STAT_ALARM |-> m_alarm_value == 12'sd0)
        else $error("alarm value without alarm");

endmodule

bind sensor_reading_table srt_checker #(.SLOTS(SLOTS)) u_srt_checker (.*);

/* dv/srt_tb_pkg.sv */
// Types and the table scoreboard for the sensor reading table testbench.
// Keeps its own copy of the table and the limits, and checks results in order.
// Depends on srt_pkg.
package srt_tb_pkg;
    import srt_pkg::*;

    localparam int         TBL_SLOTS     = 16;
    localparam logic [4:0] NO_SLOT       = 5'd16;
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]        mode;
        logic [63:0]       sensor_id;
        logic [15:0]       raw_reading;
        logic signed [8:0] override_whole;
        logic [6:0]        override_fract;
        logic              fract_given;
        logic [3:0]        slot_index;
    } sensor_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [4:0]         slot;
        logic               negative;
        logic [7:0]         whole;
        logic [6:0]         fract;
        logic [8:0]         rounded_whole;
        logic [7:0]         missed;
        logic               overridden;
        logic               is_set;
        logic signed [11:0] alarm_value;
    } table_result_t;

    class table_shadow;
        logic signed [7:0] low_limit;
        logic signed [8:0] high_limit;
        logic [7:0]        miss_cap;
        bit                in_use[TBL_SLOTS];
        logic [63:0]       owner_id[TBL_SLOTS];
        bit                has_value[TBL_SLOTS];
        bit                pinned[TBL_SLOTS];
        bit                below_zero[TBL_SLOTS];
        logic [7:0]        deg_whole[TBL_SLOTS];
        logic [6:0]        deg_hund[TBL_SLOTS];
        logic [7:0]        miss_count[TBL_SLOTS];
        table_result_t     awaited[$];
        int                errors;
        int                checked;
        int                status_seen[8];

        function new();
            low_limit  = LOW_LIMIT_RST;
            high_limit = HIGH_LIMIT_RST;
            miss_cap   = MISSED_CAP_RST;
            for (int i = 0; i < TBL_SLOTS; i++) begin
                in_use[i]     = 1'b0;
                owner_id[i]   = '0;
                has_value[i]  = 1'b0;
                pinned[i]     = 1'b0;
                below_zero[i] = 1'b0;
                deg_whole[i]  = '0;
                deg_hund[i]   = '0;
                miss_count[i] = '0;
            end
            foreach (status_seen[i]) status_seen[i] = 0;
            errors  = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [8:0] data);
            case (index)
                CFG_LOW_LIMIT:  low_limit  = data[7:0];
                CFG_HIGH_LIMIT: high_limit = data;
                CFG_MISSED_CAP: miss_cap   = data[7:0];
                default: ;
            endcase
        endfunction

        function int find_owner(logic [63:0] id);
            for (int i = 0; i < TBL_SLOTS; i++)
                if (in_use[i] && owner_id[i] == id) return i;
            return -1;
        endfunction

        function int slots_taken();
            int n;
            n = 0;
            for (int i = 0; i < TBL_SLOTS; i++) n += in_use[i];
            return n;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function table_result_t slot_view(int s);
            table_result_t r;
            r               = '0;
            r.slot          = 5'(s);
            r.negative      = below_zero[s];
            r.whole         = deg_whole[s];
            r.fract         = deg_hund[s];
            r.rounded_whole = {1'b0, deg_whole[s]} + ((deg_hund[s] > HUND_ROUND) ? 9'd1 : 9'd0);
            r.missed        = miss_count[s];
            r.overridden    = pinned[s];
            r.is_set        = has_value[s];
            return r;
        endfunction

        function void take_input(sensor_item_t it);
            table_result_t r;
            int            s;
            logic [15:0]   mag;
            int            whole_deg;
            int            frac;
            int            val;
            int            ov;
            int            av;
            r      = '0;
            r.slot = NO_SLOT;
            case (it.mode)
                MODE_READ: begin
                    mag       = it.raw_reading[15] ? 16'(~it.raw_reading + 16'd1)
                                                   : it.raw_reading;
                    whole_deg = int'(mag >> 4);
                    frac      = int'(mag[3:0]) * 100 / 16;
                    val       = it.raw_reading[15] ? -whole_deg : whole_deg;
                    s         = find_owner(it.sensor_id);
                    if (s < 0) begin
                        for (int i = 0; i < TBL_SLOTS && s < 0; i++)
                            if (!in_use[i]) s = i;
                        if (s >= 0) begin
                            in_use[s]   = 1'b1;
                            owner_id[s] = it.sensor_id;
                        end
                    end
                    if (s < 0) begin
                        r.status = STAT_FULL;
                    end else if (val < int'(low_limit) || val > int'(high_limit)) begin
                        r             = slot_view(s);
                        r.status      = STAT_ALARM;
                        r.alarm_value = 12'(val);
                    end else begin
                        has_value[s] = 1'b1;
                        if (!pinned[s]) begin
                            below_zero[s] = val < 0;
                            deg_whole[s]  = 8'(val < 0 ? -val : val);
                            deg_hund[s]   = 7'(frac);
                            miss_count[s] = '0;
                        end
                        r        = slot_view(s);
                        r.status = STAT_OK;
                    end
                end
                MODE_TICK: begin
                    for (int i = 0; i < TBL_SLOTS; i++)
                        if (in_use[i] && miss_count[i] < miss_cap)
                            miss_count[i] = miss_count[i] + 8'd1;
                    r.status = STAT_OK;
                end
                MODE_SET, MODE_CLEAR: begin
                    s = find_owner(it.sensor_id);
                    if (s < 0) begin
                        r.status = STAT_NOT_FOUND;
                    end else begin
                        if (it.mode == MODE_SET) begin
                            ov            = int'($signed(it.override_whole));
                            av            = ov < 0 ? -ov : ov;
                            has_value[s]  = 1'b1;
                            pinned[s]     = 1'b1;
                            below_zero[s] = ov < 0;
                            deg_whole[s]  = av > 255 ? 8'd255 : 8'(av);
                            if (it.fract_given)
                                deg_hund[s] = (it.override_fract > HUND_MAX) ? HUND_MAX
                                                                            : it.override_fract;
                        end else begin
                            has_value[s] = 1'b0;
                            pinned[s]    = 1'b0;
                        end
                        r        = slot_view(s);
                        r.status = STAT_OK;
                    end
                end
                MODE_QUERY: begin
                    s = int'(it.slot_index);
                    if (!has_value[s]) begin
                        r.status = STAT_EMPTY;
                        r.slot   = 5'(s);
                    end else begin
                        r        = slot_view(s);
                        r.status = STAT_OK;
                    end
                end
                default: r.status = STAT_OK;
            endcase
            awaited.push_back(r);
        endfunction

        function void compare_field(string name, logic [11:0] want, logic [11:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: result %0d, %s mismatch, expected %0d, actual %0d",
                         $time, checked, name, want, got);
            end
        endfunction

        function void match_result(table_result_t got);
            table_result_t want;
            if (got.status < 8) status_seen[got.status]++;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, status %0d slot %0d",
                         $time, got.status, got.slot);
                return;
            end
            want = awaited.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("slot", want.slot, got.slot);
            compare_field("negative", want.negative, got.negative);
            compare_field("whole", want.whole, got.whole);
            compare_field("fract", want.fract, got.fract);
            compare_field("rounded_whole", want.rounded_whole, got.rounded_whole);
            compare_field("missed", want.missed, got.missed);
            compare_field("overridden", want.overridden, got.overridden);
            compare_field("is_set", want.is_set, got.is_set);
            compare_field("alarm_value", want.alarm_value, got.alarm_value);
            checked++;
        endfunction
    endclass

endpackage

/* dv/tb_top.sv */
// Top-level testbench for the sensor reading table: directed items, then random
// phases under several limit settings, with bursty input and a stalling receiver.
// Depends on srt_pkg, srt_tb_pkg and the sensor_reading_table RTL.
module tb_top;
    import srt_pkg::*;
    import srt_tb_pkg::*;

    localparam int SLOTS      = 16;
    localparam int SETTLE     = SLOTS + 6;
    localparam int PHASES     = 6;
    localparam int PHASE_LEN  = 316;
    localparam int POOL       = 17;

    logic              aclk             = 1'b0;
    logic              aresetn          = 1'b0;
    logic              cfg_valid        = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index        = '0;
    logic [8:0]        cfg_data         = '0;
    logic              s_valid          = 1'b0;
    logic              s_ready;
    logic [2:0]        s_mode           = '0;
    logic [63:0]       s_sensor_id      = '0;
    logic [15:0]       s_raw_reading    = '0;
    logic signed [8:0] s_override_whole = '0;
    logic [6:0]        s_override_fract = '0;
    logic              s_fract_given    = 1'b0;
    logic [3:0]        s_slot_index     = '0;
    logic              m_valid;
    logic              m_ready          = 1'b0;
    logic [2:0]        m_status;
    logic [4:0]        m_slot;
    logic              m_negative;
    logic [7:0]        m_whole;
    logic [6:0]        m_fract;
    logic [8:0]        m_rounded_whole;
    logic [7:0]        m_missed;
    logic              m_overridden;
    logic              m_is_set;
    logic signed [11:0] m_alarm_value;

    table_shadow shadow;
    logic [63:0] id_pool[POOL];
    int          items_in   = 0;
    int          burst_left = 0;
    int          rx_style   = 0;
    int          rx_hold    = 0;
    int          stall_left = 0;

    sensor_reading_table #(.SLOTS(SLOTS)) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_sensor_id     (s_sensor_id),
        .s_raw_reading   (s_raw_reading),
        .s_override_whole(s_override_whole),
        .s_override_fract(s_override_fract),
        .s_fract_given   (s_fract_given),
        .s_slot_index    (s_slot_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_slot          (m_slot),
        .m_negative      (m_negative),
        .m_whole         (m_whole),
        .m_fract         (m_fract),
        .m_rounded_whole (m_rounded_whole),
        .m_missed        (m_missed),
        .m_overridden    (m_overridden),
        .m_is_set        (m_is_set),
        .m_alarm_value   (m_alarm_value)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                shadow.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) begin
                shadow.take_input('{s_mode, s_sensor_id, s_raw_reading, s_override_whole,
                                    s_override_fract, s_fract_given, s_slot_index});
                items_in++;
            end
            if (m_valid && m_ready)
                shadow.match_result('{m_status, m_slot, m_negative, m_whole, m_fract,
                                      m_rounded_whole, m_missed, m_overridden, m_is_set,
                                      m_alarm_value});
        end
    end

    always @(negedge aclk) begin
        if (rx_hold == 0) begin
            rx_style = $urandom_range(0, 2);
            rx_hold  = $urandom_range(50, 400);
        end else begin
            rx_hold--;
        end
        case (rx_style)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (stall_left > 0) begin
                    m_ready <= 1'b0;
                    stall_left--;
                end else begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 24);
                end
            end
        endcase
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic sensor_item_t make_item(logic [2:0] mode, logic [63:0] id,
                                               logic [15:0] raw, logic [8:0] ow,
                                               logic [6:0] of, logic fg, logic [3:0] idx);
        sensor_item_t it;
        it = '{mode, id, raw, ow, of, fg, idx};
        return it;
    endfunction

    function automatic sensor_item_t random_item(int tick_weight);
        sensor_item_t it;
        int           p;
        int           lo;
        int           hi;
        int           deg;
        p                 = $urandom_range(0, 99);
        it.sensor_id      = id_pool[$urandom_range(0, POOL - 1)];
        if (shadow.slots_taken() == SLOTS && $urandom_range(0, 9) == 0)
            it.sensor_id = {$urandom, $urandom};
        it.override_whole = 9'($urandom);
        it.override_fract = 7'($urandom);
        it.fract_given    = 1'($urandom);
        it.slot_index     = 4'($urandom);
        if (p < tick_weight)            it.mode = MODE_TICK;
        else if (p < tick_weight + 45)  it.mode = MODE_READ;
        else if (p < tick_weight + 57)  it.mode = MODE_SET;
        else if (p < tick_weight + 65)  it.mode = MODE_CLEAR;
        else if (p < 95)                it.mode = MODE_QUERY;
        else it.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        if ($urandom_range(0, 9) < 7) begin
            lo = int'(shadow.low_limit);
            hi = int'(shadow.high_limit);
            if (lo > hi) begin
                lo = -130;
                hi = 260;
            end
            deg = lo - 3 + int'($urandom_range(0, hi - lo + 6));
            if (deg < -2048) deg = -2048;
            if (deg > 2047) deg = 2047;
            it.raw_reading = 16'(deg * 16 + int'($urandom_range(0, 15)));
        end else begin
            it.raw_reading = 16'($urandom);
        end
        return it;
    endfunction

    task automatic put_item(input sensor_item_t it);
        s_mode           = it.mode;
        s_sensor_id      = it.sensor_id;
        s_raw_reading    = it.raw_reading;
        s_override_whole = it.override_whole;
        s_override_fract = it.override_fract;
        s_fract_given    = it.fract_given;
        s_slot_index     = it.slot_index;
        s_valid          = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic rest(input int cycles);
        s_valid = 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    task automatic send_paced(input sensor_item_t it);
        if (burst_left == 0) begin
            rest($urandom_range(1, 10));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        put_item(it);
    endtask

    task automatic wait_empty(input int max_cycles);
        int n;
        n       = 0;
        s_valid = 1'b0;
        while (shadow.pending() != 0 && n < max_cycles) begin
            @(negedge aclk);
            n++;
        end
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input int value);
        cfg_index = index;
        cfg_data  = 9'(value);
        cfg_valid = 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        int lows[PHASES];
        int highs[PHASES];
        int caps[PHASES];
        int ticks;
        lows   = '{-20, -128, 127, -5, 0, -20};
        highs  = '{128, 255, -128, 40, 0, 128};
        caps   = '{250, 3, 0, 255, 1, 250};
        shadow = new();
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < POOL; i++) id_pool[i] = {$urandom, $urandom};

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        put_item(make_item(MODE_QUERY, id_pool[0], 16'h0000, 9'h000, 7'd0, 1'b0, 4'd0));
        put_item(make_item(MODE_SET, id_pool[2], 16'h0000, 9'h00a, 7'd10, 1'b1, 4'd0));
        put_item(make_item(MODE_CLEAR, id_pool[2], 16'h0000, 9'h000, 7'd0, 1'b0, 4'd0));
        put_item(make_item(MODE_READ, id_pool[0], 16'h0000, 9'h000, 7'd0, 1'b0, 4'd0));
        put_item(make_item(MODE_READ, id_pool[1], 16'hfff8, 9'h000, 7'd0, 1'b0, 4'd0));
        put_item(make_item(MODE_READ, id_pool[1], 16'h0808, 9'h000, 7'd0, 1'b0, 4'd0));
        put_item(make_item(MODE_READ, id_pool[1], 16'h0809, 9'h000, 7'd0, 1'b0, 4'd0));
        put_item(make_item(MODE_READ, id_pool[2], 16'h8000, 9'h000, 7'd0, 1'b0, 4'd0));
        put_item(make_item(MODE_READ, id_pool[2], 16'h7fff, 9'h000, 7'd0, 1'b0, 4'd0));
        put_item(make_item(MODE_READ, id_pool[0], 16'hfec0, 9'h000, 7'd0, 1'b0, 4'd0));
        put_item(make_item(MODE_READ, id_pool[0], 16'hfebf, 9'h000, 7'd0, 1'b0, 4'd0));
        put_item(make_item(MODE_READ, id_pool[0], 16'hfeb0, 9'h000, 7'd0, 1'b0, 4'd0));
        put_item(make_item(MODE_READ, id_pool[0], 16'h0810, 9'h000, 7'd0, 1'b0, 4'd0));
        put_item(make_item(MODE_TICK, id_pool[3], 16'h0000, 9'h000, 7'd0, 1'b0, 4'd0));
        put_item(make_item(MODE_TICK, id_pool[3], 16'hffff, 9'h1ff, 7'd127, 1'b1, 4'd15));
        put_item(make_item(MODE_QUERY, id_pool[0], 16'h0000, 9'h000, 7'd0, 1'b0, 4'd0));
        put_item(make_item(MODE_SET, id_pool[0], 16'h0000, 9'sh100, 7'd127, 1'b1, 4'd0));
        put_item(make_item(MODE_READ, id_pool[0], 16'h0100, 9'h000, 7'd0, 1'b0, 4'd0));
        put_item(make_item(MODE_SET, id_pool[0], 16'h0000, 9'h0ff, 7'd5, 1'b0, 4'd0));
        put_item(make_item(MODE_CLEAR, id_pool[0], 16'h0000, 9'h000, 7'd0, 1'b0, 4'd0));
        put_item(make_item(MODE_QUERY, id_pool[0], 16'h0000, 9'h000, 7'd0, 1'b0, 4'd0));
        put_item(make_item(MODE_READ, id_pool[0], 16'h0190, 9'h000, 7'd0, 1'b0, 4'd0));
        for (logic [3:0] m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
            put_item(make_item(m[2:0], '1, 16'hffff, 9'h1ff, 7'd127, 1'b1, 4'd15));
        put_item(make_item(MODE_QUERY, id_pool[0], 16'h0000, 9'h000, 7'd0, 1'b0, 4'd15));

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_empty(200_000);
            if (ph > 0) begin
                write_reg(CFG_LOW_LIMIT, lows[ph]);
                write_reg(CFG_HIGH_LIMIT, highs[ph]);
                write_reg(CFG_MISSED_CAP, caps[ph]);
            end
            ticks = (ph == PHASES - 1) ? 40 : 12;
            for (int k = 0; k < PHASE_LEN; k++) begin
                // hold off until the table has answered everything so far
                if (k == PHASE_LEN / 2) wait_empty(200_000);
                send_paced(random_item(ticks));
            end
        end

        wait_empty(200_000);
        if (shadow.pending() != 0) begin
            shadow.errors++;
            $display("%0t: %0d expected results never arrived", $time, shadow.pending());
        end
        $display("covered %0d transfers in and %0d results checked over %0d limit settings",
                 items_in, shadow.checked, PHASES);
        $display("results by status: ok %0d, alarm %0d, full %0d, unknown id %0d, empty %0d",
                 shadow.status_seen[STAT_OK], shadow.status_seen[STAT_ALARM],
                 shadow.status_seen[STAT_FULL], shadow.status_seen[STAT_NOT_FOUND],
                 shadow.status_seen[STAT_EMPTY]);
        if (shadow.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
